// ===== hw/rtl/mbe_pkg.sv =====
// Shared types, widths, register indexes and helper functions for the
// Mandelbrot escape-time test block. No dependencies.
// Used by every module of the block and by its test bench.
package mbe_pkg;

  // Field and register widths
  localparam int COL_W      = 6;
  localparam int ROW_W      = 7;
  localparam int LIMIT_W    = 12;
  localparam int BOUND_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Fixed-point word: 48 bits signed, magnitude 47 bits
  localparam int WORD_W = 48;
  localparam int MAG_W  = WORD_W - 1;
  localparam int SUM_W  = WORD_W + 2;
  localparam int HALF_W = 24;
  localparam int ACC_W  = 2 * MAG_W;

  // Constant grid table covers every row code
  localparam int TAB_N = 2 ** ROW_W;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Parameter defaults
  localparam int GRID_SIZE_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 24;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(256);
  localparam logic [BOUND_W-1:0] BOUND_RST = BOUND_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESC_BOUND  = CFG_IDX_W'(1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  // Which product the shared multiplier is working on
  typedef enum logic [1:0] {
    PROD_RR = 2'd0,
    PROD_II = 2'd1,
    PROD_RI = 2'd2
  } prod_sel_t;

  // Clamp a widened sum to the symmetric 48-bit range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = $signed({{(SUM_W-MAG_W){1'b0}}, MAG_MAX});
    lo_lim = -hi_lim;
    if (x > hi_lim) begin
      return hi_lim[WORD_W-1:0];
    end else if (x < lo_lim) begin
      return lo_lim[WORD_W-1:0];
    end
    return x[WORD_W-1:0];
  endfunction

  // Magnitude of a word that never reaches the most negative code
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [WORD_W-1:0] x);
    logic [WORD_W-1:0] n;
    n = -x;
    return x[WORD_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/mbe_cmap.sv =====
// Grid-to-coordinate mapper: constant table of c values, one per index code,
// read at the column and at the row and registered on load. Depends on mbe_pkg.
module mbe_cmap
  import mbe_pkg::*;
#(
  parameter int GRID_SIZE     = GRID_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic [COL_W-1:0]         column,
  input  logic [ROW_W-1:0]         row,
  output logic signed [WORD_W-1:0] c_re,
  output logic signed [WORD_W-1:0] c_im
);

  // Elaboration-time value of (idx - G/2) * 3 * 2^F / G, toward zero, clamped
  function automatic logic signed [WORD_W-1:0] grid_c(input int idx);
    longint d;
    longint num;
    longint q;
    longint lim;
    d   = longint'(idx) - longint'(GRID_SIZE / 2);
    num = d * 3 * (longint'(1) << FRACTION_BITS);
    q   = num / GRID_SIZE;
    lim = (longint'(1) << MAG_W) - 1;
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return WORD_W'(q);
  endfunction

  logic signed [WORD_W-1:0] c_tab [TAB_N];

  // Build the table
  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam logic signed [WORD_W-1:0] CVAL = grid_c(i);
    assign c_tab[i] = CVAL;
  end

  // Capture c for the accepted point
  always_ff @(posedge clk) begin
    if (load) begin
      c_re <= c_tab[{{(ROW_W-COL_W){1'b0}}, column}];
      c_im <= c_tab[row];
    end
  end

endmodule

// ===== hw/rtl/mbe_qmul.sv =====
// Shared fixed-point multiplier: one 24x24 partial product per cycle, summed
// into a wide accumulator, then scaled and clamped. Depends on mbe_pkg.
module mbe_qmul
  import mbe_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [MAG_W-1:0] a_mag,
  input  logic [MAG_W-1:0] b_mag,
  output logic             done,
  output logic [MAG_W-1:0] res
);

  localparam logic [2:0] CNT_LAST = 3'd4;

  logic [MAG_W-1:0]    a_q;
  logic [MAG_W-1:0]    b_q;
  logic [2:0]          cnt;
  logic                running;
  logic [2*HALF_W-1:0] pp;
  logic [1:0]          pp_tag;
  logic                pp_v;
  logic [ACC_W-1:0]    acc;
  logic [HALF_W-1:0]   a_half;
  logic [HALF_W-1:0]   b_half;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    scaled;

  // Pick the halves for this partial product
  assign a_half = cnt[1] ? HALF_W'(a_q[MAG_W-1:HALF_W]) : a_q[HALF_W-1:0];
  assign b_half = cnt[0] ? HALF_W'(b_q[MAG_W-1:HALF_W]) : b_q[HALF_W-1:0];

  // Align the registered partial product by the weight of its halves
  always_comb begin
    case (pp_tag) inside
      2'b00:        addend = ACC_W'(pp);
      2'b01, 2'b10: addend = ACC_W'(pp) << HALF_W;
      default:      addend = ACC_W'(pp) << (2 * HALF_W);
    endcase
  end

  // Drop the fraction bits and clamp the magnitude
  assign scaled = acc >> FRACTION_BITS;
  assign res    = (scaled > ACC_W'(MAG_MAX)) ? MAG_MAX : scaled[MAG_W-1:0];

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      pp_v    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == CNT_LAST);
      pp_v <= running && !cnt[2];
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 3'd1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Multiply into a register, then accumulate the registered product in the next cycle
  always_ff @(posedge clk) begin
    pp     <= a_half * b_half;
    pp_tag <= cnt[1:0];
    if (go) begin
      a_q <= a_mag;
      b_q <= b_mag;
      acc <= '0;
    end else if (pp_v) begin
      acc <= acc + addend;
    end
  end

endmodule

// ===== hw/rtl/mandelbrot_escape_test.sv =====
// Mandelbrot escape-time test, one grid point per command.
// After start is accepted, done strobes once n passes have run, n being at
// most iteration_limit; each pass is three products of four partial
// products each, run one after another on the one shared multiplier.
// Throughput: one point at a time; busy stays high until done. No output stall.
// Reset: synchronous, active high; limit returns to 256 and bound to 2.
module mandelbrot_escape_test
  import mbe_pkg::*;
#(
  parameter int GRID_SIZE     = GRID_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COL_W-1:0]      column,
  input  logic [ROW_W-1:0]      row,
  output logic                  done,
  output logic                  inside_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                   state;
  prod_sel_t                psel;
  prod_sel_t                op_sel;
  logic [LIMIT_W-1:0]       iteration_limit;
  logic [BOUND_W-1:0]       escape_bound;
  logic [LIMIT_W-1:0]       count;
  logic signed [WORD_W-1:0] zre;
  logic signed [WORD_W-1:0] zim;
  logic signed [WORD_W-1:0] c_re;
  logic signed [WORD_W-1:0] c_im;
  logic [MAG_W-1:0]         prod_rr;
  logic [MAG_W-1:0]         prod_ii;
  logic [MAG_W-1:0]         prod_ri;
  logic [MAG_W-1:0]         re_mag;
  logic [MAG_W-1:0]         im_mag;
  logic [MAG_W-1:0]         bound;
  logic [MAG_W-1:0]         op_a;
  logic [MAG_W-1:0]         op_b;
  logic [MAG_W-1:0]         mul_res;
  logic                     mul_go;
  logic                     mul_done;
  logic                     accept;
  logic                     escaped;
  logic                     limit_hit;
  logic signed [SUM_W-1:0]  rr_s;
  logic signed [SUM_W-1:0]  ii_s;
  logic signed [SUM_W-1:0]  ri2_s;
  logic signed [SUM_W-1:0]  ri2_signed;
  logic signed [WORD_W-1:0] zre_next;
  logic signed [WORD_W-1:0] zim_next;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Map the point to c
  mbe_cmap #(
    .GRID_SIZE     (GRID_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cmap (
    .clk    (clk),
    .load   (accept),
    .column (column),
    .row    (row),
    .c_re   (c_re),
    .c_im   (c_im)
  );

  // Escape and limit tests
  assign re_mag    = mag_of(zre);
  assign im_mag    = mag_of(zim);
  assign bound     = MAG_W'(escape_bound) << FRACTION_BITS;
  assign escaped   = (re_mag > bound) || (im_mag > bound);
  assign limit_hit = (count == iteration_limit);

  // Issue products to the shared multiplier
  always_comb begin
    mul_go = 1'b0;
    op_sel = PROD_RR;
    if (state == ST_CHECK && !limit_hit && !escaped) begin
      mul_go = 1'b1;
    end else if (state == ST_WAIT && mul_done && psel != PROD_RI) begin
      mul_go = 1'b1;
      op_sel = (psel == PROD_RR) ? PROD_II : PROD_RI;
    end
  end

  always_comb begin
    unique case (op_sel)
      PROD_RR: begin
        op_a = re_mag;
        op_b = re_mag;
      end
      PROD_II: begin
        op_a = im_mag;
        op_b = im_mag;
      end
      PROD_RI: begin
        op_a = re_mag;
        op_b = im_mag;
      end
      default: begin
        op_a = re_mag;
        op_b = im_mag;
      end
    endcase
  end

  mbe_qmul #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_qmul (
    .clk   (clk),
    .rst   (rst),
    .go    (mul_go),
    .a_mag (op_a),
    .b_mag (op_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Form z*z + c from the stored products
  assign rr_s       = $signed({{(SUM_W-MAG_W){1'b0}}, prod_rr});
  assign ii_s       = $signed({{(SUM_W-MAG_W){1'b0}}, prod_ii});
  assign ri2_s      = $signed({{(SUM_W-MAG_W-1){1'b0}}, prod_ri, 1'b0});
  assign ri2_signed = (zre[WORD_W-1] ^ zim[WORD_W-1]) ? -ri2_s : ri2_s;
  assign zre_next   = sat_word(rr_s - ii_s + SUM_W'(c_re));
  assign zim_next   = sat_word(ri2_signed + SUM_W'(c_im));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RST;
      escape_bound    <= BOUND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ITER_LIMIT: iteration_limit <= cfg_data[LIMIT_W-1:0];
        REG_ESC_BOUND:  escape_bound    <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      psel  <= PROD_RR;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            count <= '0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (limit_hit || escaped) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            psel  <= PROD_RR;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mul_done) begin
            if (psel == PROD_RI) begin
              state <= ST_UPDATE;
            end else begin
              psel <= op_sel;
            end
          end
        end
        ST_UPDATE: begin
          count <= count + LIMIT_W'(1);
          state <= ST_CHECK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      zre <= '0;
      zim <= '0;
    end else if (state == ST_UPDATE) begin
      zre <= zre_next;
      zim <= zim_next;
    end
    if (state == ST_WAIT && mul_done) begin
      case (psel)
        PROD_RR: prod_rr <= mul_res;
        PROD_II: prod_ii <= mul_res;
        default: prod_ri <= mul_res;
      endcase
    end
    if (state == ST_CHECK) begin
      inside_res <= limit_hit;
    end
  end

endmodule

// ===== hw/rtl/mbe_checker.sv =====
// Port-level checker for the escape-time block, attached by bind.
// Depends on mandelbrot_escape_test.
module mbe_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted command raises busy
  ap_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted command");

  // A result beat appears only once the block has gone idle
  ap_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // Result beats never run back to back
  ap_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for two cycles");

  // Busy drops only together with a result beat
  ap_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy dropped without a result");

endmodule

bind mandelbrot_escape_test mbe_checker u_mbe_checker (.*);

// ===== tb/sv/mandelbrot_escape_test_test.sv =====
// Self-checking bench for the Mandelbrot escape-time block: drives grid points
// under several limit and bound settings and checks each inside/escaped verdict.
// Depends on mbe_pkg and the mandelbrot_escape_test RTL.
module mandelbrot_escape_test_test;
  import mbe_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 50;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_POINTS  = 100;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } grid_point_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             is_in;
  } escape_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COL_W-1:0]      column = '0;
  logic [ROW_W-1:0]      row = '0;
  logic                  done;
  logic                  inside_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers
  logic [LIMIT_W-1:0] limit_cfg = LIMIT_RST;
  logic [BOUND_W-1:0] bound_cfg = BOUND_RST;

  grid_point_t     point_q[$];
  escape_verdict_t verdict_q[$];
  grid_point_t     next_point;

  int points_total    = 0;
  int points_accepted = 0;
  int verdicts_seen   = 0;
  int inside_seen     = 0;
  int settings_seen   = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int gap_left        = 0;
  bit drain_hold      = 1'b0;
  bit burst_mode      = 1'b0;

  mandelbrot_escape_test i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .column     (column),
    .row        (row),
    .done       (done),
    .inside_res (inside_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint word_mag(logic signed [WORD_W-1:0] x);
    return (x < 0) ? -longint'(x) : longint'(x);
  endfunction

  // Clamp to the symmetric 48-bit range
  function automatic logic signed [WORD_W-1:0] clamp_word(longint x);
    longint lim;
    lim = longint'(MAG_MAX);
    if (x > lim) return WORD_W'(lim);
    if (x < -lim) return WORD_W'(-lim);
    return WORD_W'(x);
  endfunction

  // Fixed-point product: truncate the magnitude, then saturate
  function automatic logic signed [WORD_W-1:0] fixed_mul(logic signed [WORD_W-1:0] a,
                                                        logic signed [WORD_W-1:0] b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    longint       mag;
    ma = word_mag(a);
    mb = word_mag(b);
    prod = {64'd0, ma} * {64'd0, mb};
    prod = prod >> FRACTION_BITS_DEF;
    if (prod > {81'd0, MAG_MAX}) prod = {81'd0, MAG_MAX};
    mag = longint'(prod[63:0]);
    return ((a < 0) != (b < 0)) ? WORD_W'(-mag) : WORD_W'(mag);
  endfunction

  // Map a grid index to a coordinate of c
  function automatic logic signed [WORD_W-1:0] grid_coord(logic [ROW_W-1:0] idx);
    longint d;
    d = longint'(idx) - GRID_SIZE_DEF / 2;
    return clamp_word((d * 3 * (longint'(1) << FRACTION_BITS_DEF)) / GRID_SIZE_DEF);
  endfunction

  function automatic logic predict_inside(logic [COL_W-1:0] col, logic [ROW_W-1:0] rw,
                                          logic [LIMIT_W-1:0] lim, logic [BOUND_W-1:0] bnd);
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;
    logic signed [WORD_W-1:0] z_re;
    logic signed [WORD_W-1:0] z_im;
    logic signed [WORD_W-1:0] n_re;
    logic signed [WORD_W-1:0] n_im;
    longint                   bound_fx;
    c_re = grid_coord(ROW_W'(col));
    c_im = grid_coord(rw);
    bound_fx = longint'(bnd) << FRACTION_BITS_DEF;
    z_re = '0;
    z_im = '0;
    for (int k = 0; k < int'(lim); k++) begin
      if (word_mag(z_re) > bound_fx || word_mag(z_im) > bound_fx) return 1'b0;
      n_re = clamp_word(longint'(fixed_mul(z_re, z_re)) - longint'(fixed_mul(z_im, z_im))
                        + longint'(c_re));
      n_im = clamp_word(2 * longint'(fixed_mul(z_re, z_im)) + longint'(c_im));
      z_re = n_re;
      z_im = n_im;
    end
    return 1'b1;
  endfunction

  // -------------------------------------------------------------- driver side

  // Accept a point beat, record its verdict, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        verdict_q.push_back('{col: column, row: row,
                              is_in: predict_inside(column, row, limit_cfg, bound_cfg)});
        points_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (drain_hold && verdict_q.size() != 0) begin
          start <= 1'b0;
        end else if (point_q.size() != 0) begin
          next_point = point_q.pop_front();
          column <= next_point.col;
          row    <= next_point.row;
          start  <= 1'b1;
          gap_left = burst_mode ? 0 : $urandom_range(0, 17);
          drain_hold = ($urandom_range(0, 49) == 0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- monitor side

  task automatic report_mismatch(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Compare each result beat with the oldest verdict
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result inside_res=%0b with no point pending", inside_res));
      end else begin
        escape_verdict_t v;
        v = verdict_q.pop_front();
        verdicts_seen++;
        if (v.is_in) inside_seen++;
        if (inside_res !== v.is_in)
          report_mismatch($sformatf("point (%0d,%0d): inside_res=%0b, expected %0b",
                                    v.col, v.row, inside_res, v.is_in));
      end
    end
  end

  // ----------------------------------------------------------------- sequence

  task automatic add_point(int col, int rw);
    point_q.push_back('{col: COL_W'(col), row: ROW_W'(rw)});
    points_total++;
  endtask

  // Hold until every queued point is accepted and its verdict has come back
  task automatic wait_idle();
    while (points_accepted != points_total || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ITER_LIMIT) limit_cfg = data[LIMIT_W-1:0];
    else if (idx == REG_ESC_BOUND) bound_cfg = data[BOUND_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // Drain, then load a limit and a bound; junk upper bits and a spare index ride along
  task automatic new_setting(logic [LIMIT_W-1:0] lim, logic [BOUND_W-1:0] bnd);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    write_reg(REG_ITER_LIMIT, lim);
    data = CFG_DATA_W'($urandom);
    data[BOUND_W-1:0] = bnd;
    write_reg(REG_ESC_BOUND, data);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
    settings_seen++;
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    logic [BOUND_W-1:0] bnd;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: corners, edges, center, rows past the grid
    add_point(32, 32);
    add_point(0, 0);
    add_point(63, 0);
    add_point(0, 64);
    add_point(63, 64);
    add_point(0, 127);
    add_point(63, 127);
    add_point(32, 0);
    add_point(32, 64);
    add_point(0, 32);
    add_point(63, 32);
    add_point(21, 32);
    add_point(40, 40);
    add_point(32, 127);

    // Zero limit: every point is inside
    new_setting(LIMIT_W'(0), BOUND_W'(2));
    add_point(0, 0);
    add_point(63, 127);
    add_point(32, 32);

    // Zero bound: only the origin stays put
    new_setting(LIMIT_W'(8), BOUND_W'(0));
    add_point(32, 32);
    add_point(33, 32);
    add_point(32, 33);

    // Largest limit
    new_setting({LIMIT_W{1'b1}}, BOUND_W'(2));
    add_point(32, 32);
    add_point(0, 0);

    // Largest bound
    new_setting(LIMIT_W'(64), {BOUND_W{1'b1}});
    add_point(63, 64);
    add_point(0, 0);
    add_point(32, 32);

    // Random phases, mostly short limits to keep the run bounded
    for (int p = 0; p < RAND_PHASES; p++) begin
      lim = (p == 3) ? LIMIT_W'($urandom_range(33, 64)) : LIMIT_W'($urandom_range(0, 32));
      case ($urandom_range(0, 4))
        0:       bnd = BOUND_W'(0);
        1:       bnd = BOUND_W'(1);
        2:       bnd = BOUND_W'(2);
        3:       bnd = {BOUND_W{1'b1}};
        default: bnd = BOUND_W'($urandom_range(0, 255));
      endcase
      new_setting(lim, bnd);
      burst_mode = (p % 3 == 1);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if ($urandom_range(0, 7) == 0) add_point($urandom_range(0, 63), $urandom_range(65, 127));
        else add_point($urandom_range(0, 63), $urandom_range(0, 64));
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("Checked %0d grid points (%0d inside, %0d escaped) over %0d register settings.",
             verdicts_seen, inside_seen, verdicts_seen - inside_seen, settings_seen + 1);
    $display("Settings included zero and full limits, zero and full bounds, spare indexes.");
    if (error_count == 0) begin
      $display("mandelbrot_escape_test verification clean");
    end else begin
      $display("mandelbrot_escape_test verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped at cycle limit with %0d verdicts pending.", verdict_q.size());
    $display("mandelbrot_escape_test verification failed");
    $finish;
  end

endmodule
